[rtl/core/swsplit_pkg.sv]
`default_nettype none

package swsplit_pkg;

   localparam int unsigned TOKEN_LEN_W = 16;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [TOKEN_LEN_W-1:0] MAX_TOKEN_RESET = 16'd4095;

   localparam logic CSR_REG_MAX_TOKEN = 1'b0;

   localparam logic [7:0] CHAR_DOLLAR    = 8'h24;
   localparam logic [7:0] CHAR_BACKQUOTE = 8'h60;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_VTAB      = 8'h0B;
   localparam logic [7:0] CHAR_FORMFEED  = 8'h0C;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;

   typedef enum logic [2:0] {
      MODE_SKIP  = 3'd0,
      MODE_PLAIN = 3'd1,
      MODE_BSL   = 3'd2,
      MODE_SQ    = 3'd3,
      MODE_DQ    = 3'd4,
      MODE_DQBSL = 3'd5
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_type;

   typedef struct packed {
      logic [1:0] byte_count;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       token_done;
      logic       parse_error;
      logic       string_done;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/swsplit_in_stage.sv]
`default_nettype none

module swsplit_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire swsplit_pkg::req_type req_data,
   input  wire logic              advance,
   output logic                   item_valid,
   output swsplit_pkg::req_type   item_data
);

   logic                 valid_ff;
   logic                 valid_in;
   swsplit_pkg::req_type data_ff;
   logic                 accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

`default_nettype wire

[rtl/core/swsplit_scan.sv]
`default_nettype none

module swsplit_scan (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  step_en,
   input  wire swsplit_pkg::req_type                  item,
   input  wire logic [swsplit_pkg::TOKEN_LEN_W-1:0]   max_token_chars,
   output swsplit_pkg::rsp_type                       result
);

   swsplit_pkg::scan_mode_type           mode_ff, mode_in, mode_nx;
   logic                                 seen_ff, seen_in, seen_nx;
   logic [swsplit_pkg::TOKEN_LEN_W-1:0]  len_ff, len_in, len_nx, len_base;
   logic                                 err_ff, err_in, err_nx;

   logic [7:0] c;
   logic       e;
   logic       ws;
   logic       plain_path;
   logic       plain_seen;
   logic       fail;
   logic       done;
   logic [1:0] put_cnt;
   logic [7:0] put_b0;
   logic [7:0] put_b1;
   logic       put_fail;

   always_comb begin
      c  = item.in_byte;
      e  = item.string_end;
      ws = (c == swsplit_pkg::CHAR_SPACE)   || (c == swsplit_pkg::CHAR_TAB) ||
           (c == swsplit_pkg::CHAR_NEWLINE) || (c == swsplit_pkg::CHAR_VTAB) ||
           (c == swsplit_pkg::CHAR_FORMFEED) || (c == swsplit_pkg::CHAR_RETURN);

      mode_nx    = mode_ff;
      seen_nx    = seen_ff;
      len_nx     = len_ff;
      len_base   = len_ff;
      err_nx     = err_ff;
      fail       = 1'b0;
      done       = 1'b0;
      put_cnt    = 2'd0;
      put_b0     = 8'd0;
      put_b1     = 8'd0;
      plain_path = 1'b0;
      plain_seen = seen_ff;
      put_fail   = 1'b0;

      if (!err_ff) begin
         case (mode_ff)
            swsplit_pkg::MODE_PLAIN: begin
               plain_path = 1'b1;
            end
            swsplit_pkg::MODE_BSL: begin
               mode_nx = swsplit_pkg::MODE_PLAIN;
               if (c != swsplit_pkg::CHAR_NEWLINE) begin
                  put_cnt = 2'd1;
                  put_b0  = c;
               end
            end
            swsplit_pkg::MODE_SQ: begin
               if (c == swsplit_pkg::CHAR_SQUOTE) begin
                  mode_nx = swsplit_pkg::MODE_PLAIN;
                  seen_nx = 1'b1;
               end else begin
                  put_cnt = 2'd1;
                  put_b0  = c;
               end
            end
            swsplit_pkg::MODE_DQ: begin
               if (c == swsplit_pkg::CHAR_DQUOTE) begin
                  mode_nx = swsplit_pkg::MODE_PLAIN;
                  seen_nx = 1'b1;
               end else if (c == swsplit_pkg::CHAR_BACKSLASH) begin
                  if (e) begin
                     fail = 1'b1;
                  end else begin
                     mode_nx = swsplit_pkg::MODE_DQBSL;
                  end
               end else begin
                  put_cnt = 2'd1;
                  put_b0  = c;
               end
            end
            swsplit_pkg::MODE_DQBSL: begin
               mode_nx = swsplit_pkg::MODE_DQ;
               if ((c == swsplit_pkg::CHAR_DOLLAR) || (c == swsplit_pkg::CHAR_BACKQUOTE) ||
                   (c == swsplit_pkg::CHAR_DQUOTE) || (c == swsplit_pkg::CHAR_BACKSLASH)) begin
                  put_cnt = 2'd1;
                  put_b0  = c;
               end else if (c != swsplit_pkg::CHAR_NEWLINE) begin
                  put_cnt = 2'd2;
                  put_b0  = swsplit_pkg::CHAR_BACKSLASH;
                  put_b1  = c;
               end
            end
            default: begin
               mode_nx = swsplit_pkg::MODE_SKIP;
               if (!ws) begin
                  plain_path = 1'b1;
                  plain_seen = 1'b0;
                  seen_nx    = 1'b0;
                  len_base   = '0;
                  len_nx     = '0;
                  mode_nx    = swsplit_pkg::MODE_PLAIN;
               end
            end
         endcase

         if (plain_path) begin
            if (c == swsplit_pkg::CHAR_SQUOTE) begin
               mode_nx = swsplit_pkg::MODE_SQ;
               seen_nx = 1'b1;
            end else if (c == swsplit_pkg::CHAR_DQUOTE) begin
               mode_nx = swsplit_pkg::MODE_DQ;
               seen_nx = 1'b1;
            end else if (c == swsplit_pkg::CHAR_BACKSLASH) begin
               if (e) begin
                  fail = 1'b1;
               end else begin
                  mode_nx = swsplit_pkg::MODE_BSL;
               end
            end else if (ws) begin
               if (!plain_seen) begin
                  fail = 1'b1;
               end else begin
                  done    = 1'b1;
                  mode_nx = swsplit_pkg::MODE_SKIP;
               end
            end else begin
               put_cnt = 2'd1;
               put_b0  = c;
            end
         end

         if (put_cnt != 2'd0) begin
            seen_nx  = 1'b1;
            put_fail = (len_base >= max_token_chars) ||
                       ((put_cnt == 2'd2) &&
                        (({1'b0, len_base} + 17'd1) >= {1'b0, max_token_chars}));
            if (put_fail) begin
               fail = 1'b1;
            end else begin
               len_nx = len_base + {{(swsplit_pkg::TOKEN_LEN_W-2){1'b0}}, put_cnt};
            end
         end

         if (!fail && e && (mode_nx != swsplit_pkg::MODE_SKIP)) begin
            if ((mode_nx == swsplit_pkg::MODE_PLAIN) && seen_nx) begin
               done    = 1'b1;
               mode_nx = swsplit_pkg::MODE_SKIP;
            end else begin
               fail = 1'b1;
            end
         end

         if (fail) begin
            err_nx  = 1'b1;
            put_cnt = 2'd0;
            put_b0  = 8'd0;
            put_b1  = 8'd0;
            done    = 1'b0;
         end
      end

      result.byte_count  = put_cnt;
      result.first_byte  = put_b0;
      result.second_byte = put_b1;
      result.token_done  = done;
      result.parse_error = err_nx;
      result.string_done = e;

      if (e) begin
         mode_in = swsplit_pkg::MODE_SKIP;
         seen_in = 1'b0;
         len_in  = '0;
         err_in  = 1'b0;
      end else begin
         mode_in = mode_nx;
         seen_in = seen_nx;
         len_in  = len_nx;
         err_in  = err_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= swsplit_pkg::MODE_SKIP;
         seen_ff <= 1'b0;
         len_ff  <= '0;
         err_ff  <= 1'b0;
      end else if (step_en) begin
         mode_ff <= mode_in;
         seen_ff <= seen_in;
         len_ff  <= len_in;
         err_ff  <= err_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/swsplit_out_stage.sv]
`default_nettype none

module swsplit_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire swsplit_pkg::rsp_type result,
   output logic                      can_load,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output swsplit_pkg::rsp_type      rsp_data
);

   logic                 valid_ff;
   logic                 valid_in;
   swsplit_pkg::rsp_type data_ff;

   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

[rtl/core/shell_word_splitter_unit.sv]
// Beats pass the input stage register, the combinational scan and the output register.
// One beat per cycle unless stalled; word-splitting mode machine updates once per beat.
// Reset is synchronous and active high: both stages empty, scanner state cleared,
// and the token length limit returns to 4095.
`default_nettype none

module shell_word_splitter_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire swsplit_pkg::req_type                req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output swsplit_pkg::rsp_type                     rsp_data,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [swsplit_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [swsplit_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [swsplit_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                     pready
);

   logic [swsplit_pkg::TOKEN_LEN_W-1:0] max_tok_ff;
   logic                                item_valid;
   swsplit_pkg::req_type                item_data;
   swsplit_pkg::rsp_type                result;
   logic                                can_load;
   logic                                advance;
   logic                                reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[swsplit_pkg::CSR_ADDR_W-1] == swsplit_pkg::CSR_REG_MAX_TOKEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tok_ff <= swsplit_pkg::MAX_TOKEN_RESET;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         max_tok_ff <= pwdata[swsplit_pkg::TOKEN_LEN_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_hit) begin
         prdata[swsplit_pkg::TOKEN_LEN_W-1:0] = max_tok_ff;
      end
   end

   assign advance = item_valid && can_load;

   swsplit_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   swsplit_scan u_scan (
      .clock           (clock),
      .reset           (reset),
      .step_en         (advance),
      .item            (item_data),
      .max_token_chars (max_tok_ff),
      .result          (result)
   );

   swsplit_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[verif/shell_word_splitter_unit_test.sv]
`timescale 1ns / 100ps

module shell_word_splitter_unit_test;

   localparam logic [swsplit_pkg::CSR_ADDR_W-1:0] LIMIT_ADDR =
      swsplit_pkg::CSR_ADDR_W'(4 * int'(swsplit_pkg::CSR_REG_MAX_TOKEN));
   localparam swsplit_pkg::rsp_type NO_TYPED   = '0;
   localparam swsplit_pkg::rsp_type FAULT_MID  = '{2'd0, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0};
   localparam swsplit_pkg::rsp_type FAULT_LAST = '{2'd0, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1};

   typedef struct {
      logic [15:0]          new_limit;
      swsplit_pkg::req_type beat;
      bit                   typed;
      swsplit_pkg::rsp_type want;
   } plan_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   swsplit_pkg::req_type               req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   swsplit_pkg::rsp_type               rsp_data;
   logic                               psel = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite = 1'b0;
   logic [swsplit_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [swsplit_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [swsplit_pkg::CSR_DATA_W-1:0] prdata;
   logic                               pready;

   swsplit_pkg::scan_mode_type scan_state = swsplit_pkg::MODE_SKIP;
   bit                tok_seen = 1'b0;
   logic [15:0]       tok_len = '0;
   bit                err_held = 1'b0;
   logic [15:0]       tok_limit = swsplit_pkg::MAX_TOKEN_RESET;
   logic [7:0]        emit_buf [2];
   int                emit_cnt;
   bit                emit_fail;
   bit                emit_done;

   swsplit_pkg::rsp_type owed_results [$];
   swsplit_pkg::rsp_type oldest;
   plan_row_type      plan [$];
   logic [7:0]        text [$];
   bit                quiet = 1'b0;
   int                mismatch_count = 0;
   int                beats_sent = 0;
   int                strings_sent = 0;
   int                results_seen = 0;
   int                tokens_closed = 0;
   int                strings_flagged = 0;
   int                limit_settings = 0;

   shell_word_splitter_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 12);
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic bit is_blank(input logic [7:0] c);
      return c == swsplit_pkg::CHAR_SPACE || c == swsplit_pkg::CHAR_TAB ||
             c == swsplit_pkg::CHAR_NEWLINE || c == swsplit_pkg::CHAR_VTAB ||
             c == swsplit_pkg::CHAR_FORMFEED || c == swsplit_pkg::CHAR_RETURN;
   endfunction

   function automatic void emit_byte(input logic [7:0] c);
      if (emit_fail) return;
      tok_seen = 1'b1;
      if (tok_len >= tok_limit || emit_cnt >= 2) begin
         emit_fail = 1'b1;
         return;
      end
      emit_buf[emit_cnt] = c;
      emit_cnt++;
      tok_len = tok_len + 16'd1;
   endfunction

   function automatic void take_plain(input logic [7:0] c, input bit last);
      if (c == swsplit_pkg::CHAR_SQUOTE) begin
         scan_state = swsplit_pkg::MODE_SQ;
         tok_seen = 1'b1;
      end else if (c == swsplit_pkg::CHAR_DQUOTE) begin
         scan_state = swsplit_pkg::MODE_DQ;
         tok_seen = 1'b1;
      end else if (c == swsplit_pkg::CHAR_BACKSLASH) begin
         if (last) emit_fail = 1'b1;
         else scan_state = swsplit_pkg::MODE_BSL;
      end else if (is_blank(c)) begin
         if (!tok_seen) begin
            emit_fail = 1'b1;
         end else begin
            emit_done = 1'b1;
            scan_state = swsplit_pkg::MODE_SKIP;
         end
      end else begin
         emit_byte(c);
      end
   endfunction

   function automatic swsplit_pkg::rsp_type split_byte(input swsplit_pkg::req_type beat);
      swsplit_pkg::rsp_type res;
      logic [7:0]           c;
      bit                   last;
      res = '0;
      c = beat.in_byte;
      last = beat.string_end;
      emit_buf[0] = '0;
      emit_buf[1] = '0;
      emit_cnt = 0;
      emit_fail = 1'b0;
      emit_done = 1'b0;
      if (!err_held) begin
         case (scan_state)
            swsplit_pkg::MODE_PLAIN: take_plain(c, last);
            swsplit_pkg::MODE_BSL: begin
               scan_state = swsplit_pkg::MODE_PLAIN;
               if (c != swsplit_pkg::CHAR_NEWLINE) emit_byte(c);
            end
            swsplit_pkg::MODE_SQ: begin
               if (c == swsplit_pkg::CHAR_SQUOTE) begin
                  scan_state = swsplit_pkg::MODE_PLAIN;
                  tok_seen = 1'b1;
               end else begin
                  emit_byte(c);
               end
            end
            swsplit_pkg::MODE_DQ: begin
               if (c == swsplit_pkg::CHAR_DQUOTE) begin
                  scan_state = swsplit_pkg::MODE_PLAIN;
                  tok_seen = 1'b1;
               end else if (c == swsplit_pkg::CHAR_BACKSLASH) begin
                  if (last) emit_fail = 1'b1;
                  else scan_state = swsplit_pkg::MODE_DQBSL;
               end else begin
                  emit_byte(c);
               end
            end
            swsplit_pkg::MODE_DQBSL: begin
               scan_state = swsplit_pkg::MODE_DQ;
               if (c == swsplit_pkg::CHAR_DOLLAR || c == swsplit_pkg::CHAR_BACKQUOTE ||
                   c == swsplit_pkg::CHAR_DQUOTE || c == swsplit_pkg::CHAR_BACKSLASH ||
                   c == swsplit_pkg::CHAR_NEWLINE) begin
                  if (c != swsplit_pkg::CHAR_NEWLINE) emit_byte(c);
               end else begin
                  emit_byte(swsplit_pkg::CHAR_BACKSLASH);
                  emit_byte(c);
               end
            end
            default: begin
               scan_state = swsplit_pkg::MODE_SKIP;
               if (!is_blank(c)) begin
                  tok_seen = 1'b0;
                  tok_len = '0;
                  scan_state = swsplit_pkg::MODE_PLAIN;
                  take_plain(c, last);
               end
            end
         endcase
         if (!emit_fail && last && scan_state != swsplit_pkg::MODE_SKIP) begin
            if (scan_state == swsplit_pkg::MODE_PLAIN && tok_seen) begin
               emit_done = 1'b1;
               scan_state = swsplit_pkg::MODE_SKIP;
            end else begin
               emit_fail = 1'b1;
            end
         end
         if (emit_fail) begin
            err_held = 1'b1;
            emit_cnt = 0;
            emit_buf[0] = '0;
            emit_buf[1] = '0;
            emit_done = 1'b0;
         end
      end
      res.byte_count  = 2'(emit_cnt);
      res.first_byte  = emit_buf[0];
      res.second_byte = emit_buf[1];
      res.token_done  = emit_done;
      res.parse_error = err_held;
      res.string_done = last;
      if (last) begin
         scan_state = swsplit_pkg::MODE_SKIP;
         tok_seen = 1'b0;
         tok_len = '0;
         err_held = 1'b0;
      end
      return res;
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(5))
         0: return swsplit_pkg::CHAR_SPACE;
         1: return swsplit_pkg::CHAR_TAB;
         2: return swsplit_pkg::CHAR_NEWLINE;
         3: return swsplit_pkg::CHAR_VTAB;
         4: return swsplit_pkg::CHAR_FORMFEED;
         default: return swsplit_pkg::CHAR_RETURN;
      endcase
   endfunction

   function automatic logic [7:0] pick_literal();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(255));
      end while (is_blank(c) || c == swsplit_pkg::CHAR_SQUOTE ||
                 c == swsplit_pkg::CHAR_DQUOTE || c == swsplit_pkg::CHAR_BACKSLASH);
      return c;
   endfunction

   function automatic void compose_string();
      int words;
      int pieces;
      int n;
      int cut;
      text.delete();
      if ($urandom_range(99) < 8) begin
         n = $urandom_range(1, 6);
         repeat (n) text.push_back(8'($urandom_range(255)));
         return;
      end
      if ($urandom_range(99) < 30) text.push_back(pick_blank());
      words = $urandom_range(1, 4);
      for (int w = 0; w < words; w++) begin
         if (w != 0) repeat ($urandom_range(1, 2)) text.push_back(pick_blank());
         pieces = $urandom_range(1, 4);
         for (int p = 0; p < pieces; p++) begin
            case ($urandom_range(9))
               0, 1, 2, 3: repeat ($urandom_range(1, 3)) text.push_back(pick_literal());
               4, 5: begin
                  text.push_back(swsplit_pkg::CHAR_BACKSLASH);
                  text.push_back(8'($urandom_range(255)));
               end
               6: begin
                  text.push_back(swsplit_pkg::CHAR_SQUOTE);
                  repeat ($urandom_range(0, 3)) begin
                     if ($urandom_range(3) == 0) text.push_back(pick_blank());
                     else text.push_back(pick_literal());
                  end
                  text.push_back(swsplit_pkg::CHAR_SQUOTE);
               end
               7, 8: begin
                  text.push_back(swsplit_pkg::CHAR_DQUOTE);
                  repeat ($urandom_range(0, 3)) begin
                     case ($urandom_range(3))
                        0, 1: text.push_back(pick_literal());
                        2: begin
                           text.push_back(swsplit_pkg::CHAR_BACKSLASH);
                           case ($urandom_range(4))
                              0: text.push_back(swsplit_pkg::CHAR_DOLLAR);
                              1: text.push_back(swsplit_pkg::CHAR_BACKQUOTE);
                              2: text.push_back(swsplit_pkg::CHAR_DQUOTE);
                              3: text.push_back(swsplit_pkg::CHAR_BACKSLASH);
                              default: text.push_back(swsplit_pkg::CHAR_NEWLINE);
                           endcase
                        end
                        default: begin
                           text.push_back(swsplit_pkg::CHAR_BACKSLASH);
                           text.push_back(pick_literal());
                        end
                     endcase
                  end
                  text.push_back(swsplit_pkg::CHAR_DQUOTE);
               end
               default: begin
                  text.push_back(swsplit_pkg::CHAR_BACKSLASH);
                  text.push_back(swsplit_pkg::CHAR_NEWLINE);
               end
            endcase
         end
      end
      if ($urandom_range(99) < 20) text.push_back(pick_blank());
      if ($urandom_range(99) < 12) begin
         cut = $urandom_range(0, text.size() - 1);
         if ($urandom_range(1) == 0) begin
            while (text.size() > cut + 1) void'(text.pop_back());
         end else begin
            text[cut] = 8'($urandom_range(255));
         end
      end
   endfunction

   function automatic void add_step(input logic [15:0] new_limit, input logic [7:0] c,
                                    input bit last, input bit typed,
                                    input swsplit_pkg::rsp_type want);
      plan_row_type row;
      row.new_limit = new_limit;
      row.beat = '{in_byte: c, string_end: last};
      row.typed = typed;
      row.want = want;
      plan.push_back(row);
   endfunction

   task automatic send_beat(input swsplit_pkg::req_type beat, input bit typed,
                            input swsplit_pkg::rsp_type want);
      swsplit_pkg::rsp_type guess;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      guess = split_byte(beat);
      owed_results.push_back(typed ? want : guess);
      beats_sent++;
      if (beat.string_end) strings_sent++;
   endtask

   task automatic check_token_limit(input logic [15:0] want);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= LIMIT_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[15:0] != want) report_mismatch("token limit readback", prdata[15:0], want);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_token_limit(input logic [15:0] lim);
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LIMIT_ADDR;
      pwdata  <= swsplit_pkg::CSR_DATA_W'(lim);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      tok_limit = lim;
      limit_settings++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      check_token_limit(lim);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_results.size() == 0) begin
            report_mismatch("result beat with nothing owed", rsp_data, 0);
         end else begin
            oldest = owed_results.pop_front();
            results_seen++;
            if (rsp_data.token_done) tokens_closed++;
            if (rsp_data.parse_error && rsp_data.string_done) strings_flagged++;
            if (rsp_data.byte_count != oldest.byte_count)
               report_mismatch("byte_count", rsp_data.byte_count, oldest.byte_count);
            if (rsp_data.first_byte != oldest.first_byte)
               report_mismatch("first_byte", rsp_data.first_byte, oldest.first_byte);
            if (rsp_data.second_byte != oldest.second_byte)
               report_mismatch("second_byte", rsp_data.second_byte, oldest.second_byte);
            if (rsp_data.token_done != oldest.token_done)
               report_mismatch("token_done", rsp_data.token_done, oldest.token_done);
            if (rsp_data.parse_error != oldest.parse_error)
               report_mismatch("parse_error", rsp_data.parse_error, oldest.parse_error);
            if (rsp_data.string_done != oldest.string_done)
               report_mismatch("string_done", rsp_data.string_done, oldest.string_done);
         end
      end
   end

   initial begin
      #(5_000_000);
      $display("Run timed out with %0d results still owed.", owed_results.size());
      $display("shell_word_splitter_unit_test: errors");
      $finish;
   end

   initial begin
      logic [15:0] limits [6];
      int          phase_beats;
      limits = '{16'd4095, 16'd1, 16'd2, 16'd3, 16'd65535, 16'($urandom_range(4, 40))};

      add_step(0, 8'h61, 1, 1, '{2'd1, 8'h61, 8'h00, 1'b1, 1'b0, 1'b1});
      add_step(0, swsplit_pkg::CHAR_SPACE, 1, 1, '{2'd0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1});
      add_step(0, swsplit_pkg::CHAR_BACKSLASH, 1, 1, FAULT_LAST);
      add_step(0, swsplit_pkg::CHAR_SQUOTE, 0, 1, '0);
      add_step(0, 8'h78, 1, 1, FAULT_LAST);
      add_step(0, swsplit_pkg::CHAR_DQUOTE, 0, 0, NO_TYPED);
      add_step(0, swsplit_pkg::CHAR_BACKSLASH, 0, 0, NO_TYPED);
      add_step(0, swsplit_pkg::CHAR_DOLLAR, 0, 0, NO_TYPED);
      add_step(0, swsplit_pkg::CHAR_BACKSLASH, 0, 0, NO_TYPED);
      add_step(0, 8'h71, 0, 0, NO_TYPED);
      add_step(0, swsplit_pkg::CHAR_DQUOTE, 0, 0, NO_TYPED);
      add_step(0, 8'h00, 0, 0, NO_TYPED);
      add_step(0, 8'hFF, 1, 0, NO_TYPED);
      add_step(0, swsplit_pkg::CHAR_BACKSLASH, 0, 0, NO_TYPED);
      add_step(0, swsplit_pkg::CHAR_NEWLINE, 0, 0, NO_TYPED);
      add_step(0, swsplit_pkg::CHAR_SPACE, 0, 1, FAULT_MID);
      add_step(0, 8'h6B, 1, 1, FAULT_LAST);
      add_step(0, swsplit_pkg::CHAR_DQUOTE, 0, 0, NO_TYPED);
      add_step(0, swsplit_pkg::CHAR_BACKSLASH, 1, 1, FAULT_LAST);
      add_step(0, swsplit_pkg::CHAR_TAB, 0, 0, NO_TYPED);
      add_step(0, 8'h77, 0, 0, NO_TYPED);
      add_step(0, swsplit_pkg::CHAR_RETURN, 1, 0, NO_TYPED);
      add_step(16'd1, 8'h61, 0, 0, NO_TYPED);
      add_step(0, 8'h62, 1, 1, FAULT_LAST);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      check_token_limit(swsplit_pkg::MAX_TOKEN_RESET);

      foreach (plan[i]) begin
         if (plan[i].new_limit != 0) set_token_limit(plan[i].new_limit);
         send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end

      for (int phase = 0; phase < 6; phase++) begin
         set_token_limit(limits[phase]);
         quiet = (phase == 4);
         phase_beats = 0;
         while (phase_beats < 140) begin
            compose_string();
            foreach (text[i]) begin
               send_beat('{in_byte: text[i], string_end: i == text.size() - 1}, 0, NO_TYPED);
               phase_beats++;
            end
         end
      end
      quiet = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d beats in %0d strings across %0d token limit settings.",
               beats_sent, strings_sent, limit_settings);
      $display("Checked %0d results: %0d tokens closed, %0d strings flagged as malformed.",
               results_seen, tokens_closed, strings_flagged);
      if (mismatch_count == 0) begin
         $display("shell_word_splitter_unit_test: clean");
      end else begin
         $display("shell_word_splitter_unit_test: errors");
      end
      $finish;
   end

endmodule
